>>> design/slpi_pkg.sv
// Shared types, constants and helper functions of the sounding log-pressure interpolator.
package slpi_pkg;

  localparam int LEVELS = 128;
  localparam int IDX_W  = $clog2(LEVELS);
  localparam int CNT_W  = IDX_W + 1;

  // ln(2) in Q30, used by the power-of-two series.
  localparam logic [29:0] LN2_Q30 = 30'd744261118;

  localparam logic signed [23:0] S24_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] S24_MIN = -24'sh800000;

  // Valid bits of a row.
  localparam logic [4:0] V_NONE = 5'd0;
  localparam logic [4:0] V_PRES = 5'd1;
  localparam logic [4:0] V_HGHT = 5'd2;
  localparam logic [4:0] V_TEMP = 5'd4;
  localparam logic [4:0] V_DWPT = 5'd8;
  localparam logic [4:0] V_OMEG = 5'd16;

  // Commands and query kinds.
  localparam logic       CMD_WRITE = 1'b0;
  localparam logic       CMD_QUERY = 1'b1;
  localparam logic [2:0] KIND_TEMP = 3'd0;
  localparam logic [2:0] KIND_DWPT = 3'd1;
  localparam logic [2:0] KIND_HGHT = 3'd2;
  localparam logic [2:0] KIND_OMEG = 3'd3;
  localparam logic [2:0] KIND_PRES = 3'd4;

  // Configuration register index (bit 2 of the byte address).
  localparam logic REG_LEVEL_COUNT = 1'b0;

  typedef struct packed {
    logic              command;
    logic [6:0]        level_index;
    logic [16:0]       level_pressure;
    logic signed [23:0] level_height;
    logic signed [23:0] level_temperature;
    logic signed [23:0] level_dewpoint;
    logic signed [23:0] level_omega;
    logic [4:0]        valid_mask;
    logic [2:0]        query_kind;
    logic signed [23:0] query_value;
  } item_t;

  typedef struct packed {
    logic signed [23:0] value;
    logic               found;
  } result_t;

  typedef struct packed {
    logic [16:0]        p;
    logic signed [23:0] h;
    logic signed [23:0] t;
    logic signed [23:0] d;
    logic signed [23:0] o;
    logic [4:0]         v;
  } row_t;

  typedef enum logic [4:0] {
    S_IDLE, S_UP, S_DOWN, S_LLOAD, S_LNORM, S_LSQ, S_PMUL, S_HMUL, S_RSET,
    S_DIV, S_PFIN, S_HEXP, S_TMUL, S_TSUM, S_HPROD, S_HFIN, S_DONE
  } state_t;

  // Quantity of a row that a query kind returns.
  function automatic logic signed [23:0] row_value(row_t r, logic [2:0] k);
    logic signed [23:0] v;
    case (k)
      KIND_TEMP: v = r.t;
      KIND_DWPT: v = r.d;
      KIND_HGHT: v = r.h;
      KIND_OMEG: v = r.o;
      default:   v = {7'd0, r.p};
    endcase
    return v;
  endfunction

  // Valid bits needed for an exact match; none means no exact test.
  function automatic logic [4:0] rule_exact(logic [2:0] k);
    logic [4:0] m;
    case (k)
      KIND_TEMP: m = V_TEMP;
      KIND_DWPT: m = V_DWPT | V_PRES;
      KIND_HGHT: m = V_HGHT | V_PRES;
      default:   m = V_NONE;
    endcase
    return m;
  endfunction

  function automatic logic [4:0] rule_above(logic [2:0] k);
    logic [4:0] m;
    case (k)
      KIND_TEMP: m = V_TEMP;
      KIND_DWPT: m = V_DWPT;
      KIND_HGHT: m = V_HGHT | V_PRES;
      default:   m = V_OMEG;
    endcase
    return m;
  endfunction

  function automatic logic [4:0] rule_below(logic [2:0] k);
    logic [4:0] m;
    case (k)
      KIND_TEMP: m = V_TEMP;
      KIND_DWPT: m = V_DWPT;
      KIND_HGHT: m = V_HGHT;
      default:   m = V_OMEG;
    endcase
    return m;
  endfunction

  // Pressures below one are taken as one.
  function automatic logic [16:0] pos17(logic [16:0] p);
    return (p == 17'd0) ? 17'd1 : p;
  endfunction

  function automatic logic signed [23:0] sat24(logic signed [25:0] v);
    logic signed [23:0] r;
    if (v > 26'(S24_MAX)) begin
      r = S24_MAX;
    end else if (v < 26'(S24_MIN)) begin
      r = S24_MIN;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

endpackage

>>> design/sounding_log_pressure_interpolator.sv
// Top level of the sounding log-pressure interpolator: level table, search and arithmetic.
//
// Usage: a word on item is taken when start is high and busy is low. A write word
// (command 0) stores one level in the table in that cycle and gives no result;
// busy stays low, so writes may follow one another in every cycle. A query word
// (command 1) raises busy until its result word has been shown on result for
// exactly one cycle, marked by done; the receiver cannot stall and must take it.
// The level table is one synchronous memory with a registered read. A query scans
// it upwards from the surface for the level above and then downwards for the level
// below, one row per cycle. Each logarithm loads its argument, normalises it by
// left shifts and squares the mantissa once per fraction bit; divisions go through
// the shared restoring divider. A pressure-at-height query adds the 12-term power
// series, each term one multiply and one division. An exact match or a missing
// bracket ends the query at once, with no arithmetic.
// The user must write the level count over the APB-style port only while the block is
// idle; the block itself does not enforce this.
// Reset clears the level count and the sequencer; table contents are undefined
// until written.
module sounding_log_pressure_interpolator (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  slpi_pkg::item_t       item,
  output logic                  done,
  output slpi_pkg::result_t     result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  slpi_pkg::state_t state, state_next;

  // Configuration register.
  logic [7:0] level_count;

  // Level table.
  slpi_pkg::row_t mem [slpi_pkg::LEVELS];
  slpi_pkg::row_t rd_row, wrow, abv, blw;
  logic [slpi_pkg::IDX_W-1:0] rd_addr, rd_idx, abv_idx;
  logic we;

  // Query and scan control.
  logic [2:0]               kind;
  logic signed [23:0]       qv;
  logic [slpi_pkg::CNT_W-1:0] addr, n_lim;
  logic                     pend;
  logic signed [23:0]       res_val;
  logic                     res_found;

  // Logarithm unit.
  logic [1:0]  lsel;
  logic [23:0] lm24, lx;
  logic [4:0]  lip;
  logic [30:0] lm;
  logic [15:0] fr;
  logic [3:0]  lcnt;
  logic [20:0] la, lb, lq;
  logic [61:0] sq;
  logic [31:0] sq_s;

  // Multiply and divide.
  logic signed [47:0] prod;
  logic [24:0]        dvs;
  logic [47:0]        dd;
  logic [24:0]        rem;
  logic [5:0]         dcnt;
  logic               dneg, tphase;
  logic [25:0]        dr;
  logic               dge;
  logic signed [47:0] qs;

  // Power series.
  logic [5:0]  sh;
  logic [29:0] y;
  logic [30:0] term;
  logic [31:0] sum;
  logic [3:0]  tn;
  logic [48:0] hp;
  logic [60:0] tprod;
  logic [45:0] yprod;

  // Search conditions.
  logic pk, up_exact, up_above, dn_hit, up_more;
  logic signed [24:0] q25, p25;
  logic [4:0] em, am, bm;
  logic signed [23:0] va, vb;
  logic signed [21:0] den, dnum, numc, dl;
  logic signed [24:0] dv, dh, dq;
  logic signed [31:0] kk;
  logic [49:0] hrnd, hsh;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == slpi_pkg::REG_LEVEL_COUNT) ? {24'd0, level_count} : 32'd0;
  assign busy   = (state != slpi_pkg::S_IDLE);
  assign done   = (state == slpi_pkg::S_DONE);
  assign result = '{value: res_val, found: res_found};

  // Level count register.
  always_ff @(posedge clk) begin
    if (rst) begin
      level_count <= 8'd0;
    end else if (psel && penable && pwrite &&
                 paddr[2] == slpi_pkg::REG_LEVEL_COUNT) begin
      level_count <= pwdata[7:0];
    end
  end

  assign n_lim = (32'(level_count) > slpi_pkg::LEVELS) ?
                 slpi_pkg::CNT_W'(slpi_pkg::LEVELS) : slpi_pkg::CNT_W'(level_count);

  // Table write and registered read.
  assign we = (state == slpi_pkg::S_IDLE) && start && item.command == slpi_pkg::CMD_WRITE &&
              32'(item.level_index) < slpi_pkg::LEVELS;
  assign wrow = '{p: item.level_pressure, h: item.level_height, t: item.level_temperature,
                  d: item.level_dewpoint, o: item.level_omega, v: item.valid_mask};
  assign rd_addr = (state == slpi_pkg::S_DOWN) ? slpi_pkg::IDX_W'(addr - 1'b1)
                                               : slpi_pkg::IDX_W'(addr);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[item.level_index[slpi_pkg::IDX_W-1:0]] <= wrow;
    end
    rd_row <= mem[rd_addr];
    rd_idx <= rd_addr;
  end

  // Row tests of both scans.
  always_comb begin
    pk  = (kind <= slpi_pkg::KIND_OMEG);
    em  = slpi_pkg::rule_exact(kind);
    am  = slpi_pkg::rule_above(kind);
    bm  = slpi_pkg::rule_below(kind);
    q25 = 25'(qv);
    p25 = {8'd0, rd_row.p};
    up_more = (addr < n_lim);
    if (pk) begin
      up_exact = pend && em != slpi_pkg::V_NONE && p25 == q25 && (rd_row.v & em) == em;
      up_above = pend && !up_exact && (rd_row.v & am) == am &&
                 ((kind == slpi_pkg::KIND_OMEG) ? (p25 <= q25) : (p25 < q25));
      dn_hit   = pend && p25 >= q25 && (rd_row.v & bm) == bm;
    end else begin
      up_exact = pend && rd_row.h == qv && rd_row.v[0];
      up_above = pend && !up_exact && rd_row.h > qv && rd_row.v[0];
      dn_hit   = pend && rd_row.h <= qv && rd_row.v[0];
    end
  end

  // Arithmetic terms.
  always_comb begin
    va    = slpi_pkg::row_value(abv, kind);
    vb    = slpi_pkg::row_value(blw, kind);
    case (lsel)
      2'd0:    lx = {7'd0, slpi_pkg::pos17(abv.p)};
      2'd1:    lx = {7'd0, slpi_pkg::pos17(blw.p)};
      default: lx = (qv < 24'sd1) ? 24'd1 : qv;
    endcase
    sq    = 62'(lm) * 62'(lm);
    sq_s  = sq[61:30];
    den   = $signed({1'b0, lb}) - $signed({1'b0, la});
    dnum  = $signed({1'b0, lb}) - $signed({1'b0, lq});
    if (dnum < 22'sd0) begin
      numc = 22'sd0;
    end else if (dnum > den) begin
      numc = den;
    end else begin
      numc = dnum;
    end
    dv    = 25'(va) - 25'(vb);
    dl    = $signed({1'b0, la}) - $signed({1'b0, lb});
    dh    = 25'(abv.h) - 25'(blw.h);
    dq    = 25'(qv) - 25'(blw.h);
    dr    = {rem, dd[47]};
    dge   = (dr >= {1'b0, dvs});
    qs    = dneg ? -$signed(dd) : $signed(dd);
    kk    = qs[47:16];
    tprod = 61'(term) * 61'(y);
    yprod = 46'(qs[15:0]) * 46'(slpi_pkg::LN2_Q30);
    hrnd  = {1'b0, hp} + (50'd1 << (sh - 6'd1));
    hsh   = hrnd >> sh;
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= slpi_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      slpi_pkg::S_IDLE: begin
        if (start && item.command == slpi_pkg::CMD_QUERY) begin
          state_next = (item.query_kind > slpi_pkg::KIND_PRES) ? slpi_pkg::S_DONE
                                                              : slpi_pkg::S_UP;
        end
      end
      slpi_pkg::S_UP: begin
        if (up_exact) begin
          state_next = slpi_pkg::S_DONE;
        end else if (up_above) begin
          state_next = slpi_pkg::S_DOWN;
        end else if (!up_more) begin
          state_next = slpi_pkg::S_DONE;
        end
      end
      slpi_pkg::S_DOWN: begin
        if (dn_hit) begin
          state_next = (rd_idx == abv_idx) ? slpi_pkg::S_DONE : slpi_pkg::S_LLOAD;
        end else if (addr == '0) begin
          state_next = slpi_pkg::S_DONE;
        end
      end
      slpi_pkg::S_LLOAD: state_next = slpi_pkg::S_LNORM;
      slpi_pkg::S_LNORM: begin
        if (lm24[23]) begin
          state_next = slpi_pkg::S_LSQ;
        end
      end
      slpi_pkg::S_LSQ: begin
        if (lcnt == 4'd15) begin
          if (pk && lsel != 2'd2) begin
            state_next = slpi_pkg::S_LLOAD;
          end else if (!pk && lsel == 2'd0) begin
            state_next = slpi_pkg::S_LLOAD;
          end else begin
            state_next = pk ? slpi_pkg::S_PMUL : slpi_pkg::S_HMUL;
          end
        end
      end
      slpi_pkg::S_PMUL: state_next = (den > 22'sd0) ? slpi_pkg::S_RSET : slpi_pkg::S_DONE;
      slpi_pkg::S_HMUL: state_next = (dh > 25'sd0) ? slpi_pkg::S_RSET : slpi_pkg::S_DONE;
      slpi_pkg::S_RSET: state_next = slpi_pkg::S_DIV;
      slpi_pkg::S_DIV: begin
        if (dcnt == 6'd47) begin
          if (pk) begin
            state_next = slpi_pkg::S_PFIN;
          end else begin
            state_next = tphase ? slpi_pkg::S_TSUM : slpi_pkg::S_HEXP;
          end
        end
      end
      slpi_pkg::S_PFIN: state_next = slpi_pkg::S_DONE;
      slpi_pkg::S_HEXP: begin
        if (kk >= 32'sd30 || kk < -32'sd32) begin
          state_next = slpi_pkg::S_DONE;
        end else begin
          state_next = slpi_pkg::S_TMUL;
        end
      end
      slpi_pkg::S_TMUL: state_next = slpi_pkg::S_DIV;
      slpi_pkg::S_TSUM: state_next = (tn == 4'd12) ? slpi_pkg::S_HPROD : slpi_pkg::S_TMUL;
      slpi_pkg::S_HPROD: state_next = slpi_pkg::S_HFIN;
      slpi_pkg::S_HFIN: state_next = slpi_pkg::S_DONE;
      slpi_pkg::S_DONE: state_next = slpi_pkg::S_IDLE;
      default: state_next = slpi_pkg::S_IDLE;
    endcase
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      slpi_pkg::S_IDLE: begin
        if (start && item.command == slpi_pkg::CMD_QUERY) begin
          kind      <= item.query_kind;
          qv        <= item.query_value;
          addr      <= '0;
          pend      <= 1'b0;
          res_val   <= 24'sd0;
          res_found <= 1'b0;
        end
      end
      slpi_pkg::S_UP: begin
        if (up_exact) begin
          res_val   <= slpi_pkg::row_value(rd_row, kind);
          res_found <= 1'b1;
        end else if (up_above) begin
          abv     <= rd_row;
          abv_idx <= rd_idx;
          addr    <= n_lim;
          pend    <= 1'b0;
        end else if (up_more) begin
          addr <= addr + 1'b1;
          pend <= 1'b1;
        end else begin
          pend <= 1'b0;
        end
      end
      slpi_pkg::S_DOWN: begin
        if (dn_hit) begin
          blw  <= rd_row;
          lsel <= 2'd0;
          if (rd_idx == abv_idx) begin
            res_val   <= slpi_pkg::row_value(abv, kind);
            res_found <= 1'b1;
          end
        end else if (addr != '0) begin
          addr <= addr - 1'b1;
          pend <= 1'b1;
        end else begin
          pend <= 1'b0;
        end
      end
      slpi_pkg::S_LLOAD: begin
        lm24 <= lx;
        lip  <= 5'd23;
      end
      slpi_pkg::S_LNORM: begin
        if (!lm24[23]) begin
          lm24 <= {lm24[22:0], 1'b0};
          lip  <= lip - 5'd1;
        end else begin
          lm   <= {lm24, 7'd0};
          fr   <= 16'd0;
          lcnt <= 4'd0;
        end
      end
      slpi_pkg::S_LSQ: begin
        // One fraction bit per squaring of the normalised mantissa.
        lm   <= sq_s[31] ? sq_s[31:1] : sq_s[30:0];
        fr   <= {fr[14:0], sq_s[31]};
        lcnt <= lcnt + 4'd1;
        if (lcnt == 4'd15) begin
          case (lsel)
            2'd0:    la <= {lip, fr[14:0], sq_s[31]};
            2'd1:    lb <= {lip, fr[14:0], sq_s[31]};
            default: lq <= {lip, fr[14:0], sq_s[31]};
          endcase
          lsel <= lsel + 2'd1;
        end
      end
      slpi_pkg::S_PMUL: begin
        if (den > 22'sd0) begin
          prod   <= 48'(dv) * 48'(numc);
          dvs    <= 25'(den);
          tphase <= 1'b0;
        end else begin
          res_val   <= vb;
          res_found <= 1'b1;
        end
      end
      slpi_pkg::S_HMUL: begin
        if (dh > 25'sd0) begin
          prod   <= 48'(dl) * 48'(dq);
          dvs    <= dh;
          tphase <= 1'b0;
        end else begin
          res_val   <= {7'd0, slpi_pkg::pos17(blw.p)};
          res_found <= 1'b1;
        end
      end
      slpi_pkg::S_RSET: begin
        // Rounding half away from zero: divide the magnitude plus half the divisor.
        dneg <= prod[47];
        dd   <= (prod[47] ? 48'(-prod) : 48'(prod)) + {24'd0, dvs[24:1]};
        rem  <= 25'd0;
        dcnt <= 6'd0;
      end
      slpi_pkg::S_DIV: begin
        rem  <= dge ? 25'(dr - {1'b0, dvs}) : 25'(dr);
        dd   <= {dd[46:0], dge};
        dcnt <= dcnt + 6'd1;
      end
      slpi_pkg::S_PFIN: begin
        res_val   <= slpi_pkg::sat24(26'(vb) + qs[25:0]);
        res_found <= 1'b1;
      end
      slpi_pkg::S_HEXP: begin
        if (kk >= 32'sd30) begin
          res_val   <= slpi_pkg::S24_MAX;
          res_found <= 1'b1;
        end else if (kk < -32'sd32) begin
          res_val   <= 24'sd0;
          res_found <= 1'b1;
        end else begin
          sh   <= 6'(32'sd30 - kk);
          y    <= yprod[45:16];
          sum  <= 32'd1 << 30;
          term <= 31'd1 << 30;
          tn   <= 4'd1;
        end
      end
      slpi_pkg::S_TMUL: begin
        dd     <= 48'(tprod[60:30]);
        dvs    <= 25'(tn);
        dneg   <= 1'b0;
        rem    <= 25'd0;
        dcnt   <= 6'd0;
        tphase <= 1'b1;
      end
      slpi_pkg::S_TSUM: begin
        term <= dd[30:0];
        sum  <= sum + dd[31:0];
        tn   <= tn + 4'd1;
      end
      slpi_pkg::S_HPROD: begin
        hp <= 49'(slpi_pkg::pos17(blw.p)) * 49'(sum);
      end
      slpi_pkg::S_HFIN: begin
        res_val   <= (hsh > 50'(slpi_pkg::S24_MAX)) ? slpi_pkg::S24_MAX : hsh[23:0];
        res_found <= 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

>>> tb/tb.sv
// Self-checking testbench of the sounding log-pressure interpolator.
`timescale 1ns / 100ps

module tb;

  localparam int    CYCLE_LIMIT  = 6000000;
  localparam int    SETTLE       = 24;
  localparam int    PHASE_QUERIES = 36;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  slpi_pkg::item_t   item = '0;
  logic              done;
  slpi_pkg::result_t result;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [2:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  sounding_log_pressure_interpolator u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item), .done(done),
    .result(result), .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // Words waiting to be sent, and results predicted but not yet seen.
  slpi_pkg::item_t   send_queue[$];
  slpi_pkg::result_t awaited_results[$];

  // Predictor copy of the level table and of the level count.
  int          tab_p[slpi_pkg::LEVELS];
  int          tab_h[slpi_pkg::LEVELS];
  int          tab_t[slpi_pkg::LEVELS];
  int          tab_d[slpi_pkg::LEVELS];
  int          tab_o[slpi_pkg::LEVELS];
  logic [4:0]  tab_v[slpi_pkg::LEVELS];
  int          search_rows = 0;

  // Generator-side view of the loaded sounding, used to aim queries.
  int          snd_p[slpi_pkg::LEVELS];
  int          snd_h[slpi_pkg::LEVELS];

  int          errors = 0;
  int          cycles = 0;
  int          idle_left = 0;
  bit          calm = 1'b0;
  int          n_queries = 0;
  int          n_found = 0;
  int          n_writes = 0;

  // log2 in unsigned Q16, fraction by repeated squaring of a Q30 mantissa.
  function automatic longint log2_q16(longint x);
    bit [63:0] m;
    longint    t;
    longint    fr;
    int        ip;
    if (x < 1) x = 1;
    t = x;
    ip = 0;
    fr = 0;
    while (t > 1) begin
      t = t >> 1;
      ip++;
    end
    if (ip <= 30) m = 64'(x) << (30 - ip);
    else m = 64'(x) >> (ip - 30);
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 30;
      fr = fr << 1;
      if (m >= 64'h8000_0000) begin
        fr = fr | 1;
        m = m >> 1;
      end
    end
    return (longint'(ip) << 16) | fr;
  endfunction

  // 2^(f/65536) in Q30 by a twelve-term series.
  function automatic longint exp2_frac_q30(longint f);
    bit [63:0] y;
    bit [63:0] sum;
    bit [63:0] term;
    y = (64'(f) * 64'(slpi_pkg::LN2_Q30)) >> 16;
    sum = 64'd1 << 30;
    term = 64'd1 << 30;
    for (int n = 1; n <= 12; n++) begin
      term = ((term * y) >> 30) / 64'(n);
      sum = sum + term;
    end
    return longint'(sum);
  endfunction

  function automatic longint round_div(longint num, longint den);
    if (num >= 0) return (num + den / 2) / den;
    return -((-num + den / 2) / den);
  endfunction

  function automatic longint clamp_pressure(longint p);
    return (p < 1) ? 1 : p;
  endfunction

  function automatic longint quantity_of(int row, logic [2:0] kind);
    case (kind)
      slpi_pkg::KIND_TEMP: return tab_t[row];
      slpi_pkg::KIND_DWPT: return tab_d[row];
      slpi_pkg::KIND_HGHT: return tab_h[row];
      default:             return tab_o[row];
    endcase
  endfunction

  // Linear interpolation in log pressure between the bracketing rows.
  function automatic bit pressure_query(logic [2:0] kind, longint q, int n, output longint res);
    logic [4:0] ex_m;
    logic [4:0] up_m;
    logic [4:0] dn_m;
    int         above;
    int         below;
    bit         hit;
    longint     la;
    longint     lb;
    longint     lq;
    longint     den;
    longint     num;
    longint     va;
    longint     vb;
    ex_m = (kind == slpi_pkg::KIND_TEMP) ? slpi_pkg::V_TEMP :
           (kind == slpi_pkg::KIND_DWPT) ? (slpi_pkg::V_DWPT | slpi_pkg::V_PRES) :
           (kind == slpi_pkg::KIND_HGHT) ? (slpi_pkg::V_HGHT | slpi_pkg::V_PRES) :
           slpi_pkg::V_NONE;
    up_m = (kind == slpi_pkg::KIND_TEMP) ? slpi_pkg::V_TEMP :
           (kind == slpi_pkg::KIND_DWPT) ? slpi_pkg::V_DWPT :
           (kind == slpi_pkg::KIND_HGHT) ? (slpi_pkg::V_HGHT | slpi_pkg::V_PRES) :
           slpi_pkg::V_OMEG;
    dn_m = (kind == slpi_pkg::KIND_TEMP) ? slpi_pkg::V_TEMP :
           (kind == slpi_pkg::KIND_DWPT) ? slpi_pkg::V_DWPT :
           (kind == slpi_pkg::KIND_HGHT) ? slpi_pkg::V_HGHT : slpi_pkg::V_OMEG;
    res = 0;
    above = 0;
    below = 0;
    hit = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (ex_m != slpi_pkg::V_NONE && tab_p[i] == q && (tab_v[i] & ex_m) == ex_m) begin
        res = quantity_of(i, kind);
        return 1'b1;
      end
      if (((kind == slpi_pkg::KIND_OMEG) ? (tab_p[i] <= q) : (tab_p[i] < q)) &&
          (tab_v[i] & up_m) == up_m) begin
        above = i;
        hit = 1'b1;
        break;
      end
    end
    if (!hit) return 1'b0;
    hit = 1'b0;
    for (int i = n - 1; i >= 0; i--) begin
      if (tab_p[i] >= q && (tab_v[i] & dn_m) == dn_m) begin
        below = i;
        hit = 1'b1;
        break;
      end
    end
    if (!hit) return 1'b0;
    va = quantity_of(above, kind);
    vb = quantity_of(below, kind);
    if (above == below) begin
      res = va;
      return 1'b1;
    end
    la = log2_q16(clamp_pressure(tab_p[above]));
    lb = log2_q16(clamp_pressure(tab_p[below]));
    lq = log2_q16(clamp_pressure(q));
    den = lb - la;
    num = lb - lq;
    if (den <= 0) begin
      res = vb;
      return 1'b1;
    end
    if (num < 0) num = 0;
    if (num > den) num = den;
    res = vb + round_div((va - vb) * num, den);
    return 1'b1;
  endfunction

  // Pressure at a height, exponential in height between the bracketing rows.
  function automatic bit height_query(longint h, int n, output longint res);
    int        above;
    int        below;
    bit        hit;
    longint    pa;
    longint    pb;
    longint    dl;
    longint    dh;
    longint    e;
    longint    k;
    longint    f;
    longint    sh;
    bit [63:0] prod;
    res = 0;
    above = 0;
    below = 0;
    hit = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (tab_h[i] == h && tab_v[i][0]) begin
        res = tab_p[i];
        return 1'b1;
      end
      if (tab_h[i] > h && tab_v[i][0]) begin
        above = i;
        hit = 1'b1;
        break;
      end
    end
    if (!hit) return 1'b0;
    hit = 1'b0;
    for (int i = n - 1; i >= 0; i--) begin
      if (tab_h[i] <= h && tab_v[i][0]) begin
        below = i;
        hit = 1'b1;
        break;
      end
    end
    if (!hit) return 1'b0;
    if (above == below) begin
      res = tab_p[above];
      return 1'b1;
    end
    pa = clamp_pressure(tab_p[above]);
    pb = clamp_pressure(tab_p[below]);
    dh = longint'(tab_h[above]) - tab_h[below];
    if (dh <= 0) begin
      res = pb;
      return 1'b1;
    end
    dl = log2_q16(pa) - log2_q16(pb);
    e = round_div(dl * (h - tab_h[below]), dh);
    if (e >= 0) k = e / 65536;
    else k = -((-e + 65535) / 65536);
    f = e - k * 65536;
    prod = 64'(pb) * 64'(exp2_frac_q30(f));
    sh = 30 - k;
    if (sh < 1) res = 8388607;
    else if (sh > 62) res = 0;
    else res = longint'((prod + (64'd1 << (sh - 1))) >> sh);
    return 1'b1;
  endfunction

  // Applies one accepted word to the table, or queues the result it must give.
  function automatic void apply_word(slpi_pkg::item_t w);
    longint            res;
    bit                ok;
    slpi_pkg::result_t r;
    if (w.command == slpi_pkg::CMD_WRITE) begin
      tab_p[w.level_index] = int'(w.level_pressure);
      tab_h[w.level_index] = int'(w.level_height);
      tab_t[w.level_index] = int'(w.level_temperature);
      tab_d[w.level_index] = int'(w.level_dewpoint);
      tab_o[w.level_index] = int'(w.level_omega);
      tab_v[w.level_index] = w.valid_mask;
      n_writes++;
      return;
    end
    res = 0;
    ok = 1'b0;
    if (w.query_kind <= slpi_pkg::KIND_OMEG) begin
      ok = pressure_query(w.query_kind, longint'(w.query_value), search_rows, res);
    end else if (w.query_kind == slpi_pkg::KIND_PRES) begin
      ok = height_query(longint'(w.query_value), search_rows, res);
    end
    if (!ok) res = 0;
    if (res > 8388607) res = 8388607;
    if (res < -8388608) res = -8388608;
    r.value = 24'(res);
    r.found = ok;
    awaited_results.push_back(r);
    n_queries++;
    if (ok) n_found++;
  endfunction

  // Driver: keeps start up while words are waiting, with random pauses.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      if (start) begin
        apply_word(item);
        if (!calm && $urandom_range(0, 7) == 0) idle_left = $urandom_range(1, 18);
      end
      if (idle_left > 0) begin
        idle_left--;
        start <= 1'b0;
      end else if (send_queue.size() > 0) begin
        item <= send_queue.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every result word is matched against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result value=%0d found=%0b", $time,
                 result.value, result.found);
        errors++;
      end else begin
        if (result.value !== awaited_results[0].value ||
            result.found !== awaited_results[0].found) begin
          $display("%0t: mismatch expected value=%0d found=%0b actual value=%0d found=%0b",
                   $time, awaited_results[0].value, awaited_results[0].found,
                   result.value, result.found);
          errors++;
        end
        void'(awaited_results.pop_front());
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic slpi_pkg::item_t write_word(int idx, int p, int h, int t, int d, int o,
                                                 logic [4:0] mask);
    slpi_pkg::item_t w;
    w = '0;
    w.command = slpi_pkg::CMD_WRITE;
    w.level_index = 7'(idx);
    w.level_pressure = 17'(p);
    w.level_height = 24'(h);
    w.level_temperature = 24'(t);
    w.level_dewpoint = 24'(d);
    w.level_omega = 24'(o);
    w.valid_mask = mask;
    w.query_kind = 3'($urandom);
    w.query_value = 24'($urandom);
    return w;
  endfunction

  // Query words carry junk in the write fields, which the block must ignore.
  function automatic slpi_pkg::item_t query_word(logic [2:0] kind, int q);
    slpi_pkg::item_t w;
    w = slpi_pkg::item_t'($bits(slpi_pkg::item_t)'({$urandom, $urandom, $urandom,
                                                    $urandom, $urandom, $urandom}));
    w.command = slpi_pkg::CMD_QUERY;
    w.query_kind = kind;
    w.query_value = 24'(q);
    return w;
  endfunction

  task automatic wait_idle();
    while (send_queue.size() > 0 || start || awaited_results.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Writes the level count over the register port, then reads it back.
  task automatic set_level_count(int c);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {slpi_pkg::REG_LEVEL_COUNT, 2'b00};
    pwdata <= 32'(c);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    search_rows = (c > slpi_pkg::LEVELS) ? slpi_pkg::LEVELS : c;
    @(posedge clk);
    psel <= 1'b1;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[7:0] !== 8'(c)) begin
      $display("%0t: level count read expected %0d actual %0d", $time, c, prdata[7:0]);
      errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Loads a well-formed sounding into rows 0..n-1: pressure never rises, height never falls.
  task automatic load_sounding(int n);
    int p;
    int h;
    int step;
    logic [4:0] mask;
    p = $urandom_range(90000, 110000);
    h = $urandom_range(0, 100000) - 50000;
    step = (n > 1) ? 85000 / n : 85000;
    for (int i = 0; i < n; i++) begin
      mask = ($urandom_range(0, 4) == 0) ? 5'($urandom) : 5'h1F;
      snd_p[i] = p;
      snd_h[i] = h;
      send_queue.push_back(write_word(i, p, h, $urandom_range(0, 8000) - 4000,
                                      $urandom_range(0, 8000) - 6000,
                                      $urandom_range(0, 4000) - 2000, mask));
      // Now and then two rows share a pressure or a height.
      if ($urandom_range(0, 9) != 0) p = p - $urandom_range(1, step);
      if ($urandom_range(0, 9) != 0) h = h + $urandom_range(100, 60000);
      if (p < 0) p = 0;
    end
  endtask

  // One aimed query on the loaded sounding, or a noise word.
  task automatic add_query(int n);
    int pick;
    int r;
    int q;
    logic [2:0] kind;
    r = $urandom_range(0, 19);
    pick = (n > 0) ? $urandom_range(0, n - 1) : 0;
    kind = 3'($urandom_range(0, 4));
    if (r == 0) begin
      kind = 3'(slpi_pkg::KIND_PRES + 1 + $urandom_range(0, 2));
      q = $urandom;
    end else if (r == 1) begin
      kind = 3'($urandom);
      q = int'(24'($urandom));
    end else if (r == 2) begin
      send_queue.push_back(write_word($urandom_range(0, slpi_pkg::LEVELS - 1),
                                      $urandom_range(0, 110000), $urandom, $urandom,
                                      $urandom, $urandom, 5'($urandom)));
      return;
    end else if (r < 7 && n > 0) begin
      q = (kind == slpi_pkg::KIND_PRES) ? snd_h[pick] : snd_p[pick];
    end else if (kind == slpi_pkg::KIND_PRES) begin
      q = (n > 0) ? snd_h[pick] + $urandom_range(0, 120000) - 60000 : $urandom_range(0, 99);
    end else begin
      q = $urandom_range(0, 115000) - 2000;
    end
    send_queue.push_back(query_word(kind, q));
  endtask

  initial begin
    int counts[8];
    counts = '{2, 16, 128, 5, 0, 64, 1, 128};
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Empty table: every known kind, and one unknown kind, reports missing.
    for (int k = 0; k <= 4; k++) send_queue.push_back(query_word(3'(k), 0));
    send_queue.push_back(query_word(3'(slpi_pkg::KIND_PRES + 1), 8388607));
    send_queue.push_back(write_word(0, 110000, -8388608, 8388607, -8388608, 8388607, 5'h1F));
    send_queue.push_back(write_word(slpi_pkg::LEVELS - 1, 0, 8388607, -8388608, 8388607,
                                    -8388608, slpi_pkg::V_NONE));
    wait_idle();

    // One row: exact matches and missing brackets at the field extremes.
    set_level_count(1);
    send_queue.push_back(query_word(slpi_pkg::KIND_TEMP, 110000));
    send_queue.push_back(query_word(slpi_pkg::KIND_PRES, -8388608));
    send_queue.push_back(query_word(slpi_pkg::KIND_OMEG, 110000));
    send_queue.push_back(query_word(slpi_pkg::KIND_DWPT, 8388607));
    send_queue.push_back(query_word(slpi_pkg::KIND_HGHT, -8388608));
    // Two rows at the same pressure and a row at zero pressure.
    send_queue.push_back(write_word(1, 50000, 500000, -2000, -3000, 150, 5'h1F));
    send_queue.push_back(write_word(2, 50000, 500000, -2500, -3500, -150, 5'h1F));
    send_queue.push_back(write_word(3, 0, 2000000, -6000, -7000, 40, 5'h1F));
    wait_idle();

    set_level_count(4);
    send_queue.push_back(query_word(slpi_pkg::KIND_TEMP, 70000));
    send_queue.push_back(query_word(slpi_pkg::KIND_HGHT, 30000));
    send_queue.push_back(query_word(slpi_pkg::KIND_PRES, 300000));
    send_queue.push_back(query_word(slpi_pkg::KIND_PRES, 1500000));
    send_queue.push_back(query_word(slpi_pkg::KIND_OMEG, 50000));
    send_queue.push_back(query_word(slpi_pkg::KIND_TEMP, 200000));
    send_queue.push_back(query_word(slpi_pkg::KIND_DWPT, -5));
    send_queue.push_back(query_word(slpi_pkg::KIND_OMEG, 25000));
    wait_idle();

    // Random soundings under several level counts; the last phase runs without pauses.
    for (int ph = 0; ph < 8; ph++) begin
      load_sounding(counts[ph]);
      wait_idle();
      set_level_count(counts[ph]);
      if (ph == 7) calm = 1'b1;
      for (int i = 0; i < PHASE_QUERIES; i++) add_query(counts[ph]);
      wait_idle();
    end

    $display("Covered %0d table writes and %0d queries, %0d of them with a value,",
             n_writes, n_queries, n_found);
    $display("over level counts from 0 to 128 and all query kinds.");
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
design/slpi_pkg.sv
design/sounding_log_pressure_interpolator.sv
tb/tb.sv
